>>> rtl/tile_slot_allocator_lru_unit_macros.svh
// Assertion helpers for the tile slot allocator; clocked on clk_i, off in reset.
`ifndef TILE_SLOT_ALLOCATOR_LRU_UNIT_MACROS_SVH
`define TILE_SLOT_ALLOCATOR_LRU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TSA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TSA_ASSERT(lbl, prop, msg)
`define TSA_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/tsa_pkg.sv
package tsa_pkg;
  localparam int MaxSlotsDef = 1024;
  localparam int MaxSlices   = 256;
  localparam int PageLog2    = 10;
  localparam int LocalW      = 29;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoSlot  = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  localparam logic [1:0] CfgTileW   = 2'd0;
  localparam logic [1:0] CfgTileH   = 2'd1;
  localparam logic [1:0] CfgSlices  = 2'd2;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindCheck = 1'b1;
endpackage

>>> rtl/tile_slot_allocator_lru_unit.sv
// Steps: a refused request (invalid check, no slot) goes straight to the done
// step; allocate of a free slot goes through the link step; a check or an
// eviction reads the RAMs and goes through the unlink step, then finishes if its
// slot is already most recent or its tag differs, else also takes the link step.
// Items are taken one at a time; a result not taken holds the block in its last step.
// Reset (and a write to a defined register) empties all slots at once; no RAM
// clearing pass, since slots fill in index order and only filled ones are read.
`include "tile_slot_allocator_lru_unit_macros.svh"
module tile_slot_allocator_lru_unit
  import tsa_pkg::*;
#(
  parameter int MAX_SLOTS = MaxSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tile_assigned, tile_x, tile_y, tile_slice, tile_tag (from bit 0)
  input  logic [63:0] s_axis_tdata,
  // kind
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, pixel_x, pixel_y, slice_index, granted_tag (from bit 0)
  output logic [63:0] m_axis_tdata
);
  localparam int SlotW = $clog2(MAX_SLOTS);
  localparam int CntW  = SlotW + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_LINK0, ST_LINK1, ST_DONE
  } state_e;

  state_e            state_q;
  logic [3:0]        wlog_q, hlog_q;
  logic [8:0]        scnt_q;
  logic [CntW-1:0]   fill_q;
  logic [SlotW-1:0]  head_q, tail_q, slot_q;
  logic              check_q, empty_q;
  logic [31:0]       tag_q, gtag_q;
  logic [1:0]        status_q;
  logic              ovalid_q;
  logic [63:0]       odata_q;

  // layout derived from the registers
  logic              layout_ok;
  logic [3:0]        ax;
  logic [4:0]        kshift;
  logic [8:0]        active;
  logic [LocalW-1:0] total;
  logic [CntW-1:0]   cap;

  always_comb begin
    layout_ok = (wlog_q <= 4'(PageLog2)) && (hlog_q <= 4'(PageLog2));
    ax        = 4'(PageLog2) - wlog_q;
    kshift    = 5'(2 * PageLog2) - {1'b0, wlog_q} - {1'b0, hlog_q};
    active    = (scnt_q > 9'(MaxSlices)) ? 9'(MaxSlices) : scnt_q;
    total     = {{(LocalW-9){1'b0}}, active} << kshift;
    if (!layout_ok) begin
      cap = '0;
    end else if (total > LocalW'(MAX_SLOTS)) begin
      cap = CntW'(MAX_SLOTS);
    end else begin
      cap = total[CntW-1:0];
    end
  end

  // check request decode
  logic              in_assigned;
  logic [9:0]        in_x, in_y;
  logic [7:0]        in_slice;
  logic [31:0]       in_tag;
  logic [9:0]        col, row;
  logic [LocalW-1:0] local_idx;
  logic              chk_ok;

  always_comb begin
    in_assigned = s_axis_tdata[0];
    in_x        = s_axis_tdata[10:1];
    in_y        = s_axis_tdata[20:11];
    in_slice    = s_axis_tdata[28:21];
    in_tag      = s_axis_tdata[60:29];
    col         = in_x >> wlog_q;
    row         = in_y >> hlog_q;
    local_idx   = ({{(LocalW-8){1'b0}}, in_slice} << kshift)
                | ({{(LocalW-10){1'b0}}, row} << ax)
                | {{(LocalW-10){1'b0}}, col};
    chk_ok      = in_assigned && layout_ok && ({1'b0, in_slice} < active)
                && (local_idx < {{(LocalW-CntW){1'b0}}, fill_q});
  end

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  logic  alloc_new;
  assign alloc_new = (s_axis_tuser[0] == KindAlloc) && (fill_q < cap);

  // RAM ports
  logic              gen_we, prv_we, nxt_we, ram_re;
  logic [SlotW-1:0]  gen_wa, prv_wa, nxt_wa;
  logic [31:0]       gen_wd, gen_rd;
  logic [SlotW-1:0]  prv_wd, nxt_wd, prv_rd, nxt_rd;
  logic              at_head, at_tail;

  assign at_head = (slot_q == head_q);
  assign at_tail = (slot_q == tail_q);
  assign ram_re  = (state_q == ST_READ);

  always_comb begin
    gen_we = 1'b0; gen_wa = fill_q[SlotW-1:0]; gen_wd = '0;
    prv_we = 1'b0; prv_wa = nxt_rd; prv_wd = prv_rd;
    nxt_we = 1'b0; nxt_wa = prv_rd; nxt_wd = nxt_rd;
    case (state_q)
      ST_IDLE: begin
        // new slot: generation tag written as zero
        gen_we = accept && alloc_new;
      end
      ST_LINK0: begin
        gen_wa = slot_q;
        gen_wd = gen_rd + 32'd1;
        gen_we = !check_q;
        if (!(check_q && gen_rd != tag_q) && !at_head) begin
          // unlink slot from its neighbors
          nxt_we = 1'b1;
          prv_we = !at_tail;
        end
      end
      ST_LINK1: begin
        // link slot in front of the current head
        prv_wa = head_q; prv_wd = slot_q; prv_we = !empty_q;
        nxt_wa = slot_q; nxt_wd = head_q; nxt_we = !empty_q;
      end
      default: ;
    endcase
  end

  tsa_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_gen (
    .clk_i, .we_i(gen_we), .waddr_i(gen_wa), .wdata_i(gen_wd),
    .re_i(ram_re), .raddr_i(slot_q), .rdata_o(gen_rd));
  tsa_ram #(.WIDTH(SlotW), .DEPTH(MAX_SLOTS)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .re_i(ram_re), .raddr_i(slot_q), .rdata_o(prv_rd));
  tsa_ram #(.WIDTH(SlotW), .DEPTH(MAX_SLOTS)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .re_i(ram_re), .raddr_i(slot_q), .rdata_o(nxt_rd));

  // result coordinates from the slot index
  logic [31:0] s32, colv, rowv, px, py, sl;
  always_comb begin
    s32  = 32'(slot_q);
    colv = s32 & ((32'd1 << ax) - 32'd1);
    rowv = (s32 >> ax) & ((32'd1 << (4'(PageLog2) - hlog_q)) - 32'd1);
    px   = colv << wlog_q;
    py   = rowv << hlog_q;
    sl   = s32 >> kshift;
  end

  // sequencer, registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wlog_q   <= 4'd8;
      hlog_q   <= 4'd8;
      scnt_q   <= 9'd4;
      fill_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      slot_q   <= '0;
      check_q  <= 1'b0;
      empty_q  <= 1'b0;
      tag_q    <= '0;
      gtag_q   <= '0;
      status_q <= StatusOk;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      if (m_axis_tready && state_q != ST_DONE) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTileW: begin
            wlog_q <= cfg_data_i[3:0];
            fill_q <= '0;
          end
          CfgTileH: begin
            hlog_q <= cfg_data_i[3:0];
            fill_q <= '0;
          end
          CfgSlices: begin
            scnt_q <= cfg_data_i;
            fill_q <= '0;
          end
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            tag_q   <= in_tag;
            empty_q <= alloc_new && (fill_q == '0);
            gtag_q  <= '0;
            if (s_axis_tuser[0] == KindCheck) begin
              check_q <= 1'b1;
              slot_q  <= local_idx[SlotW-1:0];
              if (chk_ok) begin
                status_q <= StatusOk;
                state_q  <= ST_READ;
              end else begin
                status_q <= StatusInvalid;
                state_q  <= ST_DONE;
              end
            end else begin
              check_q <= 1'b0;
              if (alloc_new) begin
                slot_q   <= fill_q[SlotW-1:0];
                fill_q   <= fill_q + CntW'(1);
                status_q <= StatusOk;
                state_q  <= ST_LINK1;
              end else if (fill_q == '0) begin
                status_q <= StatusNoSlot;
                state_q  <= ST_DONE;
              end else begin
                slot_q   <= tail_q;
                status_q <= StatusOk;
                state_q  <= ST_READ;
              end
            end
          end
        end
        ST_READ: state_q <= ST_LINK0;
        ST_LINK0: begin
          gtag_q <= gen_rd + 32'd1;
          if (check_q && gen_rd != tag_q) begin
            status_q <= StatusInvalid;
            state_q  <= ST_DONE;
          end else if (at_head) begin
            state_q <= ST_DONE;
          end else begin
            if (at_tail) begin
              tail_q <= prv_rd;
            end
            state_q <= ST_LINK1;
          end
        end
        ST_LINK1: begin
          head_q <= slot_q;
          if (empty_q) begin
            tail_q <= slot_q;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!ovalid_q || m_axis_tready) begin
            ovalid_q <= 1'b1;
            if (status_q == StatusOk && !check_q) begin
              odata_q <= {2'b00, gtag_q, sl[7:0], py[9:0], px[9:0], StatusOk};
            end else begin
              odata_q <= {62'd0, status_q};
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  `TSA_ASSERT(a_fill_cap, fill_q <= cap, "fill count beyond capacity")
  `TSA_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE),
              "result raised outside done state")
  `TSA_NEVER(a_list_ends, (state_q == ST_IDLE) && (fill_q != '0) &&
             (({1'b0, head_q} >= fill_q) || ({1'b0, tail_q} >= fill_q)),
             "recency list end points at unfilled slot")
endmodule

>>> rtl/tsa_ram.sv
module tsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
